@@ src/eso3_pkg.sv @@
// Shared constants, state encoding and rounding helpers for the third-order
// extended state observer. No dependencies; imported by every module in src.
package eso3_pkg;

  localparam int DATA_W  = 32;  // Q16.16 word
  localparam int MUL_W   = 64;  // full product of the shared multiplier
  localparam int RND_W   = 48;  // product after the Q16.16 rounding shift
  localparam int BR_W    = 50;  // bracket accumulators, signed
  localparam int HB_W    = 40;  // bracket magnitude after clamping
  localparam int HALF_W  = 20;  // bracket magnitude split for the h product
  localparam int RAD_W   = 48;  // root unit radicand
  localparam int ROOT_W  = 24;  // root unit result
  localparam int CFG_A_W = 2;

  localparam logic [DATA_W-1:0] H_Q24         = 32'd167772;  // 0.01 in Q0.24
  localparam logic [DATA_W-1:0] DELTA_Q       = 32'd3277;    // 0.05
  localparam logic [DATA_W-1:0] SLOPE_SQRT_Q  = 32'd293086;  // delta^-1/2
  localparam logic [DATA_W-1:0] SLOPE_QUART_Q = 32'd138592;  // delta^-1/4
  localparam logic [BR_W-1:0]   BR_LIM        = {{(BR_W-HB_W){1'b0}}, 1'b1, {(HB_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] S32_MAX       = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] S32_MIN       = 32'h8000_0000;

  localparam logic [CFG_A_W-1:0] CFG_GAIN_ERROR       = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_GAIN_RATE        = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_GAIN_DISTURBANCE = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_PLANT_GAIN       = 2'd3;

  typedef enum logic [15:0] {
    ST_IDLE    = 16'h0001,
    ST_MUL_GE  = 16'h0002,
    ST_MUL_PU  = 16'h0004,
    ST_FAL_SEL = 16'h0008,
    ST_SQRT_A  = 16'h0010,
    ST_SQRT_B  = 16'h0020,
    ST_MUL_SL2 = 16'h0040,
    ST_MUL_SL4 = 16'h0080,
    ST_MUL_GR  = 16'h0100,
    ST_MUL_GD  = 16'h0200,
    ST_B3_SET  = 16'h0400,
    ST_EUL_LO  = 16'h0800,
    ST_EUL_HI  = 16'h1000,
    ST_EUL_ADD = 16'h2000,
    ST_EUL_WR  = 16'h4000,
    ST_DONE    = 16'h8000
  } state_t;

  // magnitude product back to Q16.16, round half up on the magnitude
  function automatic logic [RND_W-1:0] round16(input logic [MUL_W-1:0] p);
    logic [MUL_W-1:0] t;
    t = p + MUL_W'(32768);
    return t[MUL_W-1:16];
  endfunction

  // attach a sign to a rounded magnitude
  function automatic logic [BR_W-1:0] signed_term(input logic [RND_W-1:0] m,
                                                  input logic neg);
    logic [BR_W-1:0] x;
    x = {{(BR_W-RND_W){1'b0}}, m};
    return neg ? -x : x;
  endfunction

endpackage

@@ src/extended_state_observer_third_order_core.sv @@
// Third-order nonlinear extended state observer, signed Q16.16 throughout.
// Depends on eso3_pkg, eso3_mul (shared multiplier) and eso3_sqrt (root unit).
// Usage:
//   s_axis carries one sample per transfer: control input and measured output.
//   m_axis returns the updated output, rate and disturbance estimates, one
//   transfer per accepted sample. cfg_we/cfg_addr/cfg_data write the gains;
//   write them only while no sample is in flight.
// Timing:
//   s_axis_tready is high only while the sequencer idles, so one sample is in
//   work at a time. All arithmetic goes through one 32x32 multiplier and one
//   bit-serial root unit. When |error| exceeds the linear zone the square and
//   fourth roots are taken on the root unit, one after the other; inside the
//   linear zone slope products on the multiplier take their place. The
//   sequencer returns to idle after each result before it takes the next sample.
// Reset: rst (synchronous) clears the three estimates, zeroes the gains and
//   sets the plant gain to 1.0; both channels come up empty.
// Back-pressure:
//   The result sits in an output register; a new sample is taken while it
//   waits. If the next result finishes first, the sequencer holds it until
//   m_axis_tready frees the register.
module extended_state_observer_third_order_core import eso3_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,   // control_in[31:0], measured_out[63:32]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [95:0]         m_axis_tdata,   // output_estimate[31:0], rate_estimate[63:32],
                                              // disturbance_estimate[95:64]
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [DATA_W-1:0]   cfg_data
);

  state_t state;

  logic [DATA_W-1:0] gain_error;
  logic [DATA_W-1:0] gain_rate;
  logic [DATA_W-1:0] gain_disturbance;
  logic [DATA_W-1:0] plant_gain;

  logic [DATA_W-1:0] est_output;
  logic [DATA_W-1:0] est_rate;
  logic [DATA_W-1:0] est_disturbance;

  logic [DATA_W-1:0] e_mag;
  logic              e_neg;
  logic [DATA_W-1:0] u_mag;
  logic              u_neg;
  logic [ROOT_W-1:0] f2;
  logic [ROOT_W-1:0] f4;
  logic [BR_W-1:0]   b1;
  logic [BR_W-1:0]   b2;
  logic [BR_W-1:0]   b3;
  logic [MUL_W-1:0]  acc;
  logic [1:0]        k;

  logic in_fire;
  logic out_fire;
  logic out_free;

  logic [DATA_W-1:0] control_in;
  logic [DATA_W-1:0] measured_out;
  logic [DATA_W:0]   err_diff;
  logic [DATA_W-1:0] err_sat;
  logic [DATA_W-1:0] err_abs;
  logic [DATA_W-1:0] u_abs;
  logic [DATA_W-1:0] pg_mag;
  logic              pg_neg;

  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [MUL_W-1:0]  prod;
  logic [RND_W-1:0]  r16;

  logic              sq_start;
  logic [RAD_W-1:0]  sq_rad;
  logic [ROOT_W-1:0] sq_root;
  logic              sq_done;
  logic              big_err;

  logic [BR_W-1:0]   b_sel;
  logic [DATA_W-1:0] z_sel;
  logic              b_neg;
  logic [BR_W-1:0]   b_abs;
  logic [HB_W-1:0]   bm;
  logic [MUL_W-1:0]  rnd24;
  logic [35:0]       q36;
  logic [35:0]       z36;
  logic [35:0]       n36;
  logic [DATA_W-1:0] z_new;

  assign control_in    = s_axis_tdata[31:0];
  assign measured_out  = s_axis_tdata[63:32];
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // error z1 - y, saturated, split into sign and magnitude
  always_comb begin
    err_diff = {est_output[DATA_W-1], est_output} - {measured_out[DATA_W-1], measured_out};
    if (err_diff[DATA_W] != err_diff[DATA_W-1])
      err_sat = err_diff[DATA_W] ? S32_MIN : S32_MAX;
    else
      err_sat = err_diff[DATA_W-1:0];
    err_abs = err_sat[DATA_W-1] ? -err_sat : err_sat;
    u_abs   = control_in[DATA_W-1] ? -control_in : control_in;
    pg_neg  = plant_gain[DATA_W-1];
    pg_mag  = pg_neg ? -plant_gain : plant_gain;
  end

  assign big_err = (e_mag > DELTA_Q);
  assign r16     = round16(prod);

  // bracket for the Euler step in progress, clamped to +-2^39
  always_comb begin
    case (k)
      2'd0:    begin b_sel = b1; z_sel = est_output;      end
      2'd1:    begin b_sel = b2; z_sel = est_rate;        end
      default: begin b_sel = b3; z_sel = est_disturbance; end
    endcase
    b_neg = b_sel[BR_W-1];
    b_abs = b_neg ? -b_sel : b_sel;
    bm    = (b_abs > BR_LIM) ? BR_LIM[HB_W-1:0] : b_abs[HB_W-1:0];
    rnd24 = acc + MUL_W'(8388608);
    q36   = rnd24[59:24];
    z36   = {{4{z_sel[DATA_W-1]}}, z_sel};
    n36   = b_neg ? (z36 - q36) : (z36 + q36);
    if (n36[35:31] == 5'b00000 || n36[35:31] == 5'b11111)
      z_new = n36[DATA_W-1:0];
    else
      z_new = n36[35] ? S32_MIN : S32_MAX;
  end

  // operand select for the shared multiplier
  always_comb begin
    case (state)
      ST_MUL_GE:  begin mul_a = gain_error;       mul_b = e_mag;                end
      ST_MUL_PU:  begin mul_a = pg_mag;           mul_b = u_mag;                end
      ST_FAL_SEL: begin mul_a = e_mag;            mul_b = SLOPE_SQRT_Q;         end
      ST_MUL_SL2: begin mul_a = e_mag;            mul_b = SLOPE_QUART_Q;        end
      ST_MUL_GR:  begin mul_a = gain_rate;        mul_b = DATA_W'(f2);          end
      ST_MUL_GD:  begin mul_a = gain_disturbance; mul_b = DATA_W'(f4);          end
      ST_EUL_LO:  begin mul_a = DATA_W'(bm[HALF_W-1:0]);    mul_b = H_Q24;      end
      ST_EUL_HI:  begin mul_a = DATA_W'(bm[HB_W-1:HALF_W]); mul_b = H_Q24;      end
      default:    begin mul_a = '0;               mul_b = '0;                   end
    endcase
  end

  // first root on |e|, second on the first root
  assign sq_start = ((state == ST_FAL_SEL) && big_err) || ((state == ST_SQRT_A) && sq_done);
  assign sq_rad   = (state == ST_FAL_SEL) ? {e_mag, 16'h0000}
                                          : {8'h00, sq_root, 16'h0000};

  eso3_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  eso3_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .root     (sq_root),
    .done     (sq_done)
  );

  // sequencer, configuration and estimates
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      k                <= '0;
      m_axis_tvalid    <= 1'b0;
      gain_error       <= '0;
      gain_rate        <= '0;
      gain_disturbance <= '0;
      plant_gain       <= 32'h0001_0000;
      est_output       <= '0;
      est_rate         <= '0;
      est_disturbance  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GAIN_ERROR:       gain_error       <= cfg_data;
          CFG_GAIN_RATE:        gain_rate        <= cfg_data;
          CFG_GAIN_DISTURBANCE: gain_disturbance <= cfg_data;
          CFG_PLANT_GAIN:       plant_gain       <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_DONE && out_free)
        m_axis_tvalid <= 1'b1;
      else if (out_fire)
        m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE:    if (in_fire) state <= ST_MUL_GE;
        ST_MUL_GE:  state <= ST_MUL_PU;
        ST_MUL_PU:  state <= ST_FAL_SEL;
        ST_FAL_SEL: state <= big_err ? ST_SQRT_A : ST_MUL_SL2;
        ST_SQRT_A:  if (sq_done) state <= ST_SQRT_B;
        ST_SQRT_B:  if (sq_done) state <= ST_MUL_GR;
        ST_MUL_SL2: state <= ST_MUL_SL4;
        ST_MUL_SL4: state <= ST_MUL_GR;
        ST_MUL_GR:  state <= ST_MUL_GD;
        ST_MUL_GD:  state <= ST_B3_SET;
        ST_B3_SET: begin
          k     <= '0;
          state <= ST_EUL_LO;
        end
        ST_EUL_LO:  state <= ST_EUL_HI;
        ST_EUL_HI:  state <= ST_EUL_ADD;
        ST_EUL_ADD: state <= ST_EUL_WR;
        ST_EUL_WR: begin
          case (k)
            2'd0:    est_output      <= z_new;
            2'd1:    est_rate        <= z_new;
            default: est_disturbance <= z_new;
          endcase
          k     <= k + 1'b1;
          state <= (k == 2'd2) ? ST_DONE : ST_EUL_LO;
        end
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          e_mag <= err_abs;
          e_neg <= err_sat[DATA_W-1];
          u_mag <= u_abs;
          u_neg <= control_in[DATA_W-1];
        end
      end
      ST_MUL_PU:  b1 <= {{(BR_W-DATA_W){est_rate[DATA_W-1]}}, est_rate} - signed_term(r16, e_neg);
      ST_FAL_SEL: b2 <= {{(BR_W-DATA_W){est_disturbance[DATA_W-1]}}, est_disturbance}
                        + signed_term(r16, pg_neg ^ u_neg);
      ST_SQRT_A:  if (sq_done) f2 <= sq_root;
      ST_SQRT_B:  if (sq_done) f4 <= sq_root;
      ST_MUL_SL2: f2 <= r16[ROOT_W-1:0];
      ST_MUL_SL4: f4 <= r16[ROOT_W-1:0];
      ST_MUL_GD:  b2 <= b2 - signed_term(r16, e_neg);
      ST_B3_SET:  b3 <= signed_term(r16, !e_neg);
      ST_EUL_HI:  acc <= prod;
      ST_EUL_ADD: acc <= acc + {prod[MUL_W-HALF_W-1:0], {HALF_W{1'b0}}};
      ST_DONE: begin
        if (out_free) m_axis_tdata <= {est_disturbance, est_rate, est_output};
      end
      default: ;
    endcase
  end

endmodule

@@ src/eso3_mul.sv @@
// Shared unsigned 32x32 multiplier with registered product.
// Depends on eso3_pkg for widths.
module eso3_mul import eso3_pkg::*; (
  input  logic              clk,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [MUL_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= MUL_W'(a) * MUL_W'(b);
  end

endmodule

@@ src/eso3_sqrt.sv @@
// Bit-serial integer square root, one result bit per cycle (floor).
// Depends on eso3_pkg for widths.
module eso3_sqrt import eso3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              active;

  logic [ROOT_W+3:0] tmp;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+3:0] diff;
  logic              fits;

  assign tmp   = {rem, rad[RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign diff  = tmp - trial;
  assign fits  = (tmp >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == LAST);
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (active) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem  <= diff[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= tmp[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule
